// ===== rtl/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  // Result field widths.
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;

  // Operation codes carried on the action field.
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  // Which partial product the shared multiplier forms in a given cycle.
  localparam logic [1:0] MUL_P1 = 2'd0;
  localparam logic [1:0] MUL_P2 = 2'd1;
  localparam logic [1:0] MUL_P3 = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_SETUP,
    ST_GCD,
    ST_DIVT,
    ST_DIVB,
    ST_FIN
  } rau_state_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic [1:0] mul_sel;
    logic       setup;
    logic       gcd_step;
    logic       div_init;
    logic       div_bot;
    logic       div_step;
    logic       keep_q;
    logic       out_load;
  } rau_cmd_t;

  typedef struct packed {
    logic err;
    logic gcd_done;
    logic div_done;
  } rau_status_t;

endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: controller plus datapath.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------
//   input   | in_valid / in_ready  | action, a_num, a_den, b_num, b_den
//   output  | out_valid / out_ready| res_num, res_den, div_zero
//
// One item at a time. An item is accepted, its three partial products are
// formed on one shared W x W multiplier, they are combined, binary gcd steps
// run until done, two restoring divisions reduce numerator and denominator,
// and the output register is loaded. An error item goes from the first
// multiply state straight to the output load.
// Reset (rst, synchronous) clears the state machine and output valid.
// A finished result sits in the output register; the next item is accepted
// and worked on meanwhile and holds at the end until the register frees.
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          action,
  input  logic signed [OPERAND_WIDTH-1:0]     a_num,
  input  logic signed [OPERAND_WIDTH-1:0]     a_den,
  input  logic signed [OPERAND_WIDTH-1:0]     b_num,
  input  logic signed [OPERAND_WIDTH-1:0]     b_den,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rau_pkg::NUM_W-1:0]    res_num,
  output logic [rau_pkg::DEN_W-1:0]           res_den,
  output logic                                div_zero
);

  // Commands down to the datapath, status back up.
  rau_pkg::rau_cmd_t    cmd;
  rau_pkg::rau_status_t status;

  // Sequence the multiply, combine, gcd and two divisions.
  rau_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold operands, partial products, gcd state, divider and result register.
  rau_datapath #(
    .W (OPERAND_WIDTH)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .status   (status),
    .action   (action),
    .a_num    (a_num),
    .a_den    (a_den),
    .b_num    (b_num),
    .b_den    (b_den),
    .res_num  (res_num),
    .res_den  (res_den),
    .div_zero (div_zero)
  );

endmodule

// ===== rtl/rau_controller.sv =====
// Sequencing state machine for the rational arithmetic unit.
module rau_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rau_pkg::rau_status_t status,
  output rau_pkg::rau_cmd_t    cmd
);

  rau_pkg::rau_state_t state, state_next;
  logic out_valid_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rau_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rau_pkg::ST_IDLE:  if (in_valid) state_next = rau_pkg::ST_MUL1;
      rau_pkg::ST_MUL1: begin
        state_next = status.err ? rau_pkg::ST_FIN : rau_pkg::ST_MUL2;
      end
      rau_pkg::ST_MUL2:  state_next = rau_pkg::ST_MUL3;
      rau_pkg::ST_MUL3:  state_next = rau_pkg::ST_SETUP;
      rau_pkg::ST_SETUP: state_next = rau_pkg::ST_GCD;
      rau_pkg::ST_GCD:   if (status.gcd_done) state_next = rau_pkg::ST_DIVT;
      rau_pkg::ST_DIVT:  if (status.div_done) state_next = rau_pkg::ST_DIVB;
      rau_pkg::ST_DIVB:  if (status.div_done) state_next = rau_pkg::ST_FIN;
      rau_pkg::ST_FIN:   if (out_free) state_next = rau_pkg::ST_IDLE;
      default:           state_next = rau_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      rau_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rau_pkg::ST_MUL1: begin
        cmd.mul     = !status.err;
        cmd.mul_sel = rau_pkg::MUL_P1;
      end
      rau_pkg::ST_MUL2: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = rau_pkg::MUL_P2;
      end
      rau_pkg::ST_MUL3: begin
        cmd.mul     = 1'b1;
        cmd.mul_sel = rau_pkg::MUL_P3;
      end
      rau_pkg::ST_SETUP: cmd.setup = 1'b1;
      rau_pkg::ST_GCD: begin
        cmd.gcd_step = !status.gcd_done;
        cmd.div_init = status.gcd_done;
      end
      rau_pkg::ST_DIVT: begin
        cmd.div_step = !status.div_done;
        cmd.keep_q   = status.div_done;
        cmd.div_init = status.div_done;
        cmd.div_bot  = status.div_done;
      end
      rau_pkg::ST_DIVB: cmd.div_step = !status.div_done;
      rau_pkg::ST_FIN: begin
        cmd.out_load = out_free;
        if (out_free) out_valid_next = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/rau_datapath.sv =====
// Multiplier, binary gcd and restoring divider datapath for the rational unit.
module rau_datapath #(
  parameter int W = 16
) (
  input  logic                                clk,
  input  rau_pkg::rau_cmd_t                   cmd,
  output rau_pkg::rau_status_t                status,
  input  logic [1:0]                          action,
  input  logic signed [W-1:0]                 a_num,
  input  logic signed [W-1:0]                 a_den,
  input  logic signed [W-1:0]                 b_num,
  input  logic signed [W-1:0]                 b_den,
  output logic signed [rau_pkg::NUM_W-1:0]    res_num,
  output logic [rau_pkg::DEN_W-1:0]           res_den,
  output logic                                div_zero
);

  localparam int MW  = 2 * W;
  localparam int KW  = $clog2(MW + 1);
  localparam int EXT = (MW > rau_pkg::NUM_W) ? MW : rau_pkg::NUM_W;

  function automatic logic [W-1:0] mag_of(input logic [W-1:0] x);
    mag_of = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  // Operand registers, sign and magnitude.
  logic [1:0]    op;
  logic          err;
  logic [W-1:0]  an_m, ad_m, bn_m, bd_m;
  logic          an_s, ad_s, bn_s, bd_s;

  // Partial products.
  logic [MW-1:0] p1, p2, p3;
  logic          s1, s2, s3;

  // Reduction state.
  logic [MW-1:0] top_m, bot_m, u, v;
  logic [KW-1:0] k;
  logic          res_neg;

  // Divider state.
  logic [MW-1:0] dq, rem, dvs, qt;
  logic [KW-1:0] cnt;

  // Shared multiplier operand selection.
  logic [W-1:0]  mul_x, mul_y;
  logic          mul_xs, mul_ys;
  logic [MW-1:0] mul_p;

  always_comb begin
    case (cmd.mul_sel)
      rau_pkg::MUL_P1: begin
        mul_x  = an_m;
        mul_xs = an_s;
        mul_y  = (op == rau_pkg::ACT_MUL) ? bn_m : bd_m;
        mul_ys = (op == rau_pkg::ACT_MUL) ? bn_s : bd_s;
      end
      rau_pkg::MUL_P2: begin
        mul_x  = ad_m;
        mul_xs = ad_s;
        mul_y  = (op == rau_pkg::ACT_MUL) ? bd_m : bn_m;
        mul_ys = (op == rau_pkg::ACT_MUL) ? bd_s : bn_s;
      end
      default: begin
        mul_x  = ad_m;
        mul_xs = ad_s;
        mul_y  = bd_m;
        mul_ys = bd_s;
      end
    endcase
  end

  assign mul_p = MW'(mul_x) * MW'(mul_y);

  // Combine partial products into the raw numerator and denominator.
  logic          addsub;
  logic          sb;
  logic [MW-1:0] sum_m, raw_top, raw_bot;
  logic          sum_neg, raw_tneg, raw_bneg;

  always_comb begin
    addsub = op inside {rau_pkg::ACT_ADD, rau_pkg::ACT_SUB};
    sb     = s2 ^ ((op == rau_pkg::ACT_SUB) && (p2 != '0));
    if (s1 == sb) begin
      sum_m   = p1 + p2;
      sum_neg = s1;
    end else if (p1 >= p2) begin
      sum_m   = p1 - p2;
      sum_neg = s1;
    end else begin
      sum_m   = p2 - p1;
      sum_neg = sb;
    end
    if (addsub) begin
      raw_top  = sum_m;
      raw_tneg = sum_neg && (sum_m != '0);
      raw_bot  = p3;
      raw_bneg = s3;
    end else begin
      raw_top  = p1;
      raw_tneg = s1;
      raw_bot  = p2;
      raw_bneg = s2;
    end
  end

  // Gcd value and divider step.
  logic [MW-1:0] g;
  logic [MW:0]   rem_sh;
  logic          ge;

  assign g      = v << k;
  assign rem_sh = {rem, dq[MW-1]};
  assign ge     = rem_sh >= {1'b0, dvs};

  assign status.err      = err;
  assign status.gcd_done = (u == '0);
  assign status.div_done = (cnt == '0);

  // Result formatting.
  logic [EXT-1:0] num_w, num_s, den_w;

  assign num_w = EXT'(qt);
  assign num_s = res_neg ? (~num_w + 1'b1) : num_w;
  assign den_w = EXT'(dq);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= action;
      err  <= (a_den == '0) || (b_den == '0) ||
              ((action == rau_pkg::ACT_DIV) && (b_num == '0));
      an_m <= mag_of(a_num);
      ad_m <= mag_of(a_den);
      bn_m <= mag_of(b_num);
      bd_m <= mag_of(b_den);
      an_s <= a_num[W-1];
      ad_s <= a_den[W-1];
      bn_s <= b_num[W-1];
      bd_s <= b_den[W-1];
    end

    if (cmd.mul) begin
      case (cmd.mul_sel)
        rau_pkg::MUL_P1: begin
          p1 <= mul_p;
          s1 <= (mul_xs ^ mul_ys) && (mul_p != '0);
        end
        rau_pkg::MUL_P2: begin
          p2 <= mul_p;
          s2 <= (mul_xs ^ mul_ys) && (mul_p != '0);
        end
        default: begin
          p3 <= mul_p;
          s3 <= (mul_xs ^ mul_ys) && (mul_p != '0);
        end
      endcase
    end

    if (cmd.setup) begin
      top_m   <= raw_top;
      bot_m   <= raw_bot;
      u       <= raw_top;
      v       <= raw_bot;
      k       <= '0;
      res_neg <= (raw_top != '0) && (raw_tneg != raw_bneg);
    end

    // Binary gcd: strip common twos, then halve or subtract.
    if (cmd.gcd_step) begin
      if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        k <= k + 1'b1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u >= v) begin
        u <= u - v;
      end else begin
        v <= v - u;
      end
    end

    if (cmd.keep_q) qt <= dq;

    if (cmd.div_init) begin
      dq  <= cmd.div_bot ? bot_m : top_m;
      dvs <= g;
      rem <= '0;
      cnt <= KW'(MW);
    end else if (cmd.div_step) begin
      rem <= ge ? rem_sh[MW-1:0] - dvs : rem_sh[MW-1:0];
      dq  <= {dq[MW-2:0], ge};
      cnt <= cnt - 1'b1;
    end

    if (cmd.out_load) begin
      div_zero <= err;
      res_num  <= err ? '0 : num_s[rau_pkg::NUM_W-1:0];
      res_den  <= err ? rau_pkg::DEN_W'(1) : den_w[rau_pkg::DEN_W-1:0];
    end
  end

endmodule

// ===== rtl/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, with its bind.
module rau_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [rau_pkg::NUM_W-1:0] res_num,
  input logic [rau_pkg::DEN_W-1:0]        res_den,
  input logic                             div_zero
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_num) &&
      $stable(res_den) && $stable(div_zero))
    else $error("stalled result changed");

  // The denominator is never zero.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> res_den != '0)
    else $error("zero denominator on output");

  // An error result reads 0/1.
  a_err_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_zero |-> res_num == '0 && res_den == rau_pkg::DEN_W'(1))
    else $error("error result is not 0/1");

  // A zero numerator comes with denominator one.
  a_zero_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_num == '0 |-> res_den == rau_pkg::DEN_W'(1))
    else $error("zero result not reduced to 0/1");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .res_num   (res_num),
  .res_den   (res_den),
  .div_zero  (div_zero)
);
